FILE: rtl/io_port_register_block_macros.svh
// assertion macros shared by the port block checker
// no dependencies; included by files that assert
`ifndef IO_PORT_REGISTER_BLOCK_MACROS_SVH
`define IO_PORT_REGISTER_BLOCK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IOP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IOP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/iop_pkg.sv
// types, constants and offset tables of the i/o port register block
// no dependencies
`default_nettype none

package iop_pkg;

    localparam int PORT_COUNT   = 9;
    localparam int WINDOW_BYTES = 16;
    localparam int OFF_W        = $clog2(WINDOW_BYTES);
    localparam int IDX_W        = $clog2(PORT_COUNT);
    localparam int PORT_W       = 4;
    localparam int ADDR_W       = 24;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] ALL_ONES    = 8'hFF;

    localparam logic [PORT_W-1:0] PORT_NONE          = 4'd0;
    localparam logic [PORT_W-1:0] PORT_1             = 4'd1;
    localparam logic [PORT_W-1:0] PORT_2             = 4'd2;
    localparam logic [PORT_W-1:0] PORT_3             = 4'd3;
    localparam logic [PORT_W-1:0] PORT_INPUT_ONLY_A  = 4'd7;  // variant 0
    localparam logic [PORT_W-1:0] PORT_INPUT_ONLY_B  = 4'd8;  // variant 1
    localparam logic [PORT_W-1:0] PORT_9             = 4'd9;

    localparam logic [2:0] MODE_SINGLE_CHIP = 3'd7;
    localparam logic [2:0] MODE_BUS16_A     = 3'd2;
    localparam logic [2:0] MODE_BUS16_B     = 3'd4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_CHIP_VARIANT   = 3'd0,
        CFG_OPERATING_MODE = 3'd1,
        CFG_P2_ADDR_BUS    = 3'd2,
        CFG_BLOCK_BASE     = 3'd3,
        CFG_PORT9_ADDR     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic              chip_variant;
        logic [2:0]        operating_mode;
        logic              p2_addr_bus;
        logic [ADDR_W-1:0] block_base_address;
        logic [ADDR_W-1:0] port9_address;
    } cfg_t;

    // port file access for one beat
    typedef struct packed {
        logic             dir_we;
        logic             lat_we;
        logic             pin_we;
        logic [IDX_W-1:0] port_idx;
        logic [IDX_W-1:0] pin_idx;
        logic [7:0]       wdata;
    } port_wr_t;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic [PORT_W-1:0] changed_port;
        logic [7:0]        changed_latch;
        logic [7:0]        changed_direction;
    } result_t;

    // data register offsets, same for both variants
    function automatic logic [PORT_W-1:0] dr_port(input logic [OFF_W-1:0] off);
        logic [PORT_W-1:0] p;
        unique case (off)
            4'd2:    p = 4'd1;
            4'd3:    p = 4'd2;
            4'd6:    p = 4'd3;
            4'd7:    p = 4'd4;
            4'd10:   p = 4'd5;
            4'd11:   p = 4'd6;
            4'd14:   p = 4'd7;
            4'd15:   p = 4'd8;
            default: p = PORT_NONE;
        endcase
        return p;
    endfunction

    // direction register offsets, variant 0
    function automatic logic [PORT_W-1:0] ddr_port_a(input logic [OFF_W-1:0] off);
        logic [PORT_W-1:0] p;
        unique case (off)
            4'd0:    p = 4'd1;
            4'd1:    p = 4'd2;
            4'd4:    p = 4'd3;
            4'd5:    p = 4'd4;
            4'd8:    p = 4'd5;
            4'd9:    p = 4'd6;
            4'd13:   p = 4'd8;
            default: p = PORT_NONE;
        endcase
        return p;
    endfunction

    // direction register offsets, variant 1
    function automatic logic [PORT_W-1:0] ddr_port_b(input logic [OFF_W-1:0] off);
        logic [PORT_W-1:0] p;
        unique case (off)
            4'd0:    p = 4'd1;
            4'd1:    p = 4'd2;
            4'd5:    p = 4'd4;
            4'd8:    p = 4'd5;
            4'd9:    p = 4'd6;
            4'd12:   p = 4'd7;
            default: p = PORT_NONE;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/iop_decode.sv
// address decode, read data mix and change report for one beat
// depends on iop_pkg
`default_nettype none

module iop_decode (
    input  iop_pkg::cfg_t                   cfg,
    input  iop_pkg::cmd_t                   cmd,
    input  logic [iop_pkg::ADDR_W-1:0]      bus_address,
    input  logic [7:0]                      write_byte,
    input  logic [iop_pkg::PORT_W-1:0]      pin_port,
    input  logic [7:0]                      port_dir,
    input  logic [7:0]                      port_lat,
    input  logic [7:0]                      port_pin,
    output iop_pkg::port_wr_t               wr,
    output iop_pkg::result_t                result
);
    import iop_pkg::*;

    logic [ADDR_W:0]   diff;
    logic [ADDR_W:0]   p9_dr_addr;
    logic              in_window;
    logic [OFF_W-1:0]  off;
    logic              p9_en;
    logic              hit_ddr9;
    logic              hit_dr9;
    logic [PORT_W-1:0] ddr_p;
    logic [PORT_W-1:0] dr_p;
    logic [PORT_W-1:0] input_only;
    logic [PORT_W-1:0] sel_port;
    logic              sel_ddr;
    logic [PORT_W-1:0] sel_m1;
    logic [PORT_W-1:0] pin_m1;
    logic [7:0]        mixed;

    // data register read with bus-mode and input-only overrides
    function automatic logic [7:0] read_data(
        input logic [PORT_W-1:0] port,
        input cfg_t              c,
        input logic [7:0]        dr,
        input logic [7:0]        dd,
        input logic [7:0]        pn
    );
        logic [7:0] v;
        logic [7:0] mix;
        logic       expanded;
        logic       bus16;
        expanded = c.operating_mode != MODE_SINGLE_CHIP;
        bus16    = (c.operating_mode == MODE_BUS16_A) || (c.operating_mode == MODE_BUS16_B);
        mix      = (dr & dd) | (pn & ~dd);
        if (c.chip_variant) begin
            priority if (((port == PORT_1) || (port == PORT_2)) && expanded)
                v = dr;
            else if ((port == PORT_3) && expanded)
                v = ALL_ONES;
            else if (port == PORT_INPUT_ONLY_B)
                v = pn;
            else
                v = mix;
        end else begin
            priority if ((port == PORT_1) && bus16)
                v = ALL_ONES;
            else if ((port == PORT_2) && c.p2_addr_bus)
                v = dr;
            else if (port == PORT_INPUT_ONLY_A)
                v = pn & NIBBLE_MASK;
            else
                v = mix;
        end
        return v;
    endfunction

    always_comb
    begin
        // window test without wrap: a borrow means the address is below the base
        diff       = {1'b0, bus_address} - {1'b0, cfg.block_base_address};
        in_window  = !diff[ADDR_W] && (diff[ADDR_W-1:OFF_W] == '0);
        off        = diff[OFF_W-1:0];
        p9_en      = |cfg.port9_address;
        p9_dr_addr = {1'b0, cfg.port9_address} + {{ADDR_W{1'b0}}, 1'b1};
        hit_ddr9   = p9_en && (bus_address == cfg.port9_address);
        hit_dr9    = p9_en && ({1'b0, bus_address} == p9_dr_addr);
        ddr_p      = cfg.chip_variant ? ddr_port_b(off) : ddr_port_a(off);
        dr_p       = dr_port(off);
        input_only = cfg.chip_variant ? PORT_INPUT_ONLY_B : PORT_INPUT_ONLY_A;

        sel_port = PORT_NONE;
        sel_ddr  = 1'b0;
        priority if (hit_ddr9)
        begin
            sel_port = PORT_9;
            sel_ddr  = 1'b1;
        end
        else if (hit_dr9)
        begin
            sel_port = PORT_9;
        end
        else if (in_window)
        begin
            if (ddr_p != PORT_NONE)
            begin
                sel_port = ddr_p;
                sel_ddr  = 1'b1;
            end
            else
            begin
                sel_port = dr_p;
            end
        end
        else
        begin
            sel_port = PORT_NONE;
            sel_ddr  = 1'b0;
        end

        sel_m1 = (sel_port != PORT_NONE) ? (sel_port - PORT_1) : '0;
        pin_m1 = pin_port - PORT_1;

        wr.port_idx = sel_m1[IDX_W-1:0];
        wr.wdata    = write_byte;
        wr.dir_we   = (cmd == CMD_WRITE) && (sel_port != PORT_NONE) && sel_ddr;
        wr.lat_we   = (cmd == CMD_WRITE) && (sel_port != PORT_NONE) && !sel_ddr
                      && (sel_port != input_only);
        wr.pin_we   = (cmd == CMD_PIN) && (pin_port >= PORT_1) && (pin_port <= PORT_9);
        wr.pin_idx  = wr.pin_we ? pin_m1[IDX_W-1:0] : '0;

        mixed = read_data(sel_port, cfg, port_lat, port_dir, port_pin);

        result = '0;
        unique case (cmd)
            CMD_READ:
            begin
                if ((sel_port != PORT_NONE) && !sel_ddr)
                    result.read_byte = mixed;
                else
                    result.read_byte = ALL_ONES;
            end
            CMD_WRITE:
            begin
                if (wr.dir_we || wr.lat_we)
                begin
                    result.changed_port      = sel_port;
                    result.changed_latch     = wr.lat_we ? write_byte : port_lat;
                    result.changed_direction = wr.dir_we ? write_byte : port_dir;
                end
            end
            CMD_PIN, CMD_NOP:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/io_port_register_block.sv
// top level of the i/o port register block: config, beat stages, port file
// depends on iop_pkg and iop_decode
`default_nettype none

// Parallel i/o port register block, nine 8-bit ports.
// slave channel s_*: one bus read, bus write or pin update per beat.
//   the kind travels in s_tuser, the address and data in s_tdata.
// master channel m_*: exactly one result beat for every slave beat, in order.
// config port: cfg_wr_en, cfg_index, cfg_wr_data; a register is written on any edge
//   with cfg_wr_en high; the user writes only while the block is empty, it is not enforced.
// path: a beat is captured in the input stage, then decoded and committed to
//   the port file and the result register together once that register is free
//   or taken; the result register drives the master side until the beat is taken.
// throughput: one beat per cycle while m_tready stays high, set by the single
//   decode pass between the input stage and the result register; the port file
//   is written in the same pass, so the next beat already sees the update.
// stall: when m_tready is low the result register holds, the input stage
//   fills and then s_tready drops; nothing is lost or repeated.
// reset: all ports clear to zero direction, latch and pins; the registers
//   return to variant 0, mode 7, port 2 not an address bus, window and
//   port 9 at address 0 (port 9 absent). both stages come up empty.
module io_port_register_block (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wr_data,
    // slave channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // bus_address[23:0], write_byte[31:24], pin_port[35:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // master channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_byte[7:0], changed_port[11:8],
                                   // changed_latch[19:12], changed_direction[27:20]
);
    import iop_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // input stage
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [7:0]        in_byte_reg;
    logic [PORT_W-1:0] in_pin_port_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_reg;

    // port file
    logic [7:0] dir_reg [PORT_COUNT];
    logic [7:0] lat_reg [PORT_COUNT];
    logic [7:0] pin_reg [PORT_COUNT];

    logic       advance;
    logic       commit;
    port_wr_t   wr;
    result_t    result;
    logic [7:0] port_dir;
    logic [7:0] port_lat;
    logic [7:0] port_pin;

    // the input stage moves on whenever the result register is free or taken
    assign advance  = !out_valid_reg || m_tready;
    assign commit   = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign port_dir = dir_reg[wr.port_idx];
    assign port_lat = lat_reg[wr.port_idx];
    assign port_pin = pin_reg[wr.port_idx];

    iop_decode u_decode (
        .cfg         (cfg_reg),
        .cmd         (in_cmd_reg),
        .bus_address (in_addr_reg),
        .write_byte  (in_byte_reg),
        .pin_port    (in_pin_port_reg),
        .port_dir    (port_dir),
        .port_lat    (port_lat),
        .port_pin    (port_pin),
        .wr          (wr),
        .result      (result)
    );

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chip_variant       <= 1'b0;
            cfg_reg.operating_mode     <= MODE_SINGLE_CHIP;
            cfg_reg.p2_addr_bus        <= 1'b0;
            cfg_reg.block_base_address <= '0;
            cfg_reg.port9_address      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CHIP_VARIANT:   cfg_reg.chip_variant       <= cfg_wr_data[0];
                CFG_OPERATING_MODE: cfg_reg.operating_mode     <= cfg_wr_data[2:0];
                CFG_P2_ADDR_BUS:    cfg_reg.p2_addr_bus        <= cfg_wr_data[0];
                CFG_BLOCK_BASE:     cfg_reg.block_base_address <= cfg_wr_data;
                CFG_PORT9_ADDR:     cfg_reg.port9_address      <= cfg_wr_data;
                default:            ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input stage payload, cleared so the decode sees a no-op after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cmd_reg      <= CMD_NOP;
            in_addr_reg     <= '0;
            in_byte_reg     <= '0;
            in_pin_port_reg <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_cmd_reg      <= cmd_t'(s_tuser);
            in_addr_reg     <= s_tdata[23:0];
            in_byte_reg     <= s_tdata[31:24];
            in_pin_port_reg <= s_tdata[35:32];
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (commit)
            out_reg <= result;
    end

    // port file, updated as each beat commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                dir_reg[i] <= '0;
                lat_reg[i] <= '0;
                pin_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            if (wr.dir_we)
                dir_reg[wr.port_idx] <= wr.wdata;
            if (wr.lat_we)
                lat_reg[wr.port_idx] <= wr.wdata;
            if (wr.pin_we)
                pin_reg[wr.pin_idx] <= wr.wdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.changed_direction, out_reg.changed_latch,
                       out_reg.changed_port, out_reg.read_byte};

endmodule

`default_nettype wire

FILE: rtl/iop_checker.sv
// port-level checks of the i/o port register block, bound to its top level
// depends on io_port_register_block_macros.svh
`default_nettype none

`include "io_port_register_block_macros.svh"

module iop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result beat holds
    `IOP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // no change reported means latch and direction fields are clear
    `IOP_ASSERT_IMPLY(a_no_change_clear, clk, rst_n, m_tvalid && (m_tdata[11:8] == 4'd0), m_tdata[27:12] == 16'd0, "change fields set without a changed port")

    // a write that changed a port returns no read data, and the port is in range
    `IOP_ASSERT_IMPLY(a_change_no_read, clk, rst_n, m_tvalid && (m_tdata[11:8] != 4'd0), (m_tdata[7:0] == 8'd0) && (m_tdata[11:8] <= 4'd9), "bad change report")

    // padding above the packed fields stays zero
    `IOP_ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[31:28] == 4'd0, "result padding not zero")

endmodule

bind io_port_register_block iop_checker u_iop_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/io_port_register_block_checker.sv
// result checker for the i/o port register block: follows config writes and
// slave beats, predicts every result beat and compares it with the master side
// depends on iop_pkg
`default_nettype none

module io_port_register_block_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // bus_address[23:0], write_byte[31:24], pin_port[35:32]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // read_byte[7:0], changed_port[11:8],
                                        // changed_latch[19:12], changed_direction[27:20]
    output int               pending,
    output int               errors,
    output int               checked
);
    import iop_pkg::*;

    // port number per window offset, one nibble each, offset 0 in the low nibble
    localparam logic [63:0] DATA_REG_MAP  = 64'h8700_6500_4300_2100;
    localparam logic [63:0] DIR_REG_MAP_A = 64'h0080_0065_0043_0021;
    localparam logic [63:0] DIR_REG_MAP_B = 64'h0007_0065_0040_0021;

    logic              variant;
    logic [2:0]        mode;
    logic              p2_addr_bus;
    logic [ADDR_W-1:0] window_base;
    logic [ADDR_W-1:0] port9_base;

    logic [7:0] dir_q   [PORT_COUNT];
    logic [7:0] latch_q [PORT_COUNT];
    logic [7:0] pins_q  [PORT_COUNT];

    result_t port_results[$];
    int      fail_count;
    int      compared;

    function automatic logic [7:0] port_readback(logic [3:0] port);
        logic [3:0] idx;
        logic [7:0] lat;
        logic [7:0] dir;
        logic [7:0] pin;
        idx = port - 4'd1;
        lat = latch_q[idx];
        dir = dir_q[idx];
        pin = pins_q[idx];
        if (variant)
        begin
            if ((port == PORT_1 || port == PORT_2) && mode != MODE_SINGLE_CHIP)
                return lat;
            if (port == PORT_3 && mode != MODE_SINGLE_CHIP)
                return ALL_ONES;
            if (port == PORT_INPUT_ONLY_B)
                return pin;
        end
        else
        begin
            if (port == PORT_1 && (mode == MODE_BUS16_A || mode == MODE_BUS16_B))
                return ALL_ONES;
            if (port == PORT_2 && p2_addr_bus)
                return lat;
            if (port == PORT_INPUT_ONLY_A)
                return pin & NIBBLE_MASK;
        end
        return (lat & dir) | (pin & ~dir);
    endfunction

    // applies one beat to the port state and returns its result
    function automatic result_t port_access(cmd_t cmd, logic [23:0] addr, logic [7:0] val,
                                            logic [3:0] pin_port);
        result_t    r;
        logic [24:0] off;
        logic       in_window;
        logic       hit_p9_dir;
        logic       hit_p9_data;
        logic [3:0] dir_port;
        logic [3:0] data_port;
        logic [3:0] chg;
        r           = '0;
        chg         = PORT_NONE;
        off         = {1'b0, addr} - {1'b0, window_base};
        in_window   = (addr >= window_base) && (off < WINDOW_BYTES);
        hit_p9_dir  = (port9_base != '0) && (addr == port9_base);
        hit_p9_data = (port9_base != '0) && ({1'b0, addr} == {1'b0, port9_base} + 25'd1);
        data_port   = DATA_REG_MAP[{off[3:0], 2'b00} +: 4];
        dir_port    = variant ? DIR_REG_MAP_B[{off[3:0], 2'b00} +: 4]
                              : DIR_REG_MAP_A[{off[3:0], 2'b00} +: 4];
        case (cmd)
            CMD_READ:
            begin
                r.read_byte = ALL_ONES;
                if (hit_p9_data)
                    r.read_byte = port_readback(PORT_9);
                else if (!hit_p9_dir && in_window && dir_port == PORT_NONE
                         && data_port != PORT_NONE)
                    r.read_byte = port_readback(data_port);
            end
            CMD_WRITE:
            begin
                if (hit_p9_dir || hit_p9_data)
                begin
                    if (hit_p9_dir)
                        dir_q[PORT_COUNT-1] = val;
                    else
                        latch_q[PORT_COUNT-1] = val;
                    chg = PORT_9;
                end
                else if (in_window)
                begin
                    if (dir_port != PORT_NONE)
                    begin
                        dir_q[dir_port - 4'd1] = val;
                        chg = dir_port;
                    end
                    else if (data_port != PORT_NONE && data_port !=
                             (variant ? PORT_INPUT_ONLY_B : PORT_INPUT_ONLY_A))
                    begin
                        latch_q[data_port - 4'd1] = val;
                        chg = data_port;
                    end
                end
                if (chg != PORT_NONE)
                begin
                    r.changed_port      = chg;
                    r.changed_latch     = latch_q[chg - 4'd1];
                    r.changed_direction = dir_q[chg - 4'd1];
                end
            end
            CMD_PIN:
            begin
                if (pin_port >= PORT_1 && pin_port <= PORT_9)
                    pins_q[pin_port - 4'd1] = val;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                dir_q[i]   = '0;
                latch_q[i] = '0;
                pins_q[i]  = '0;
            end
            variant     = 1'b0;
            mode        = MODE_SINGLE_CHIP;
            p2_addr_bus = 1'b0;
            window_base = '0;
            port9_base  = '0;
            port_results.delete();
            fail_count  = 0;
            compared    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CHIP_VARIANT:   variant     = cfg_wr_data[0];
                    CFG_OPERATING_MODE: mode        = cfg_wr_data[2:0];
                    CFG_P2_ADDR_BUS:    p2_addr_bus = cfg_wr_data[0];
                    CFG_BLOCK_BASE:     window_base = cfg_wr_data;
                    CFG_PORT9_ADDR:     port9_base  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.read_byte         = m_tdata[7:0];
                got.changed_port      = m_tdata[11:8];
                got.changed_latch     = m_tdata[19:12];
                got.changed_direction = m_tdata[27:20];
                if (port_results.size() == 0)
                begin
                    $error("result beat 0x%08h with no access outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = port_results.pop_front();
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("changed_port", want.changed_port, got.changed_port);
                    check_field("changed_latch", want.changed_latch, got.changed_latch);
                    check_field("changed_direction", want.changed_direction,
                                got.changed_direction);
                    compared++;
                end
            end
            if (s_tvalid && s_tready)
                port_results.push_back(port_access(cmd_t'(s_tuser), s_tdata[23:0],
                                                   s_tdata[31:24], s_tdata[35:32]));
        end
        pending <= port_results.size();
        errors  <= fail_count;
        checked <= compared;
    end

endmodule

`default_nettype wire

FILE: verif/tb_io_port_register_block.sv
// testbench top of the i/o port register block: clock, reset, config writes,
// directed and random access beats, idling phases and the verdict
// depends on iop_pkg, io_port_register_block and io_port_register_block_checker
`default_nettype none

module tb_io_port_register_block;
    import iop_pkg::*;

    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 180;
    localparam int IDLE_PCT        = 73;   // one side idling alone
    localparam int BOTH_IDLE_PCT   = 32;   // both sides idling together
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // bus_address[23:0], write_byte[31:24], pin_port[35:32]
    logic [1:0]  s_tuser = '0;     // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;          // read_byte[7:0], changed_port[11:8],
                                   // changed_latch[19:12], changed_direction[27:20]

    int pending;
    int errors;
    int checked;

    // stimulus controls
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          beats_sent = 0;
    int          idle_cycles = 0;
    logic [23:0] cur_base = '0;
    logic [23:0] cur_p9   = '0;

    io_port_register_block i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    io_port_register_block_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending),
        .errors      (errors),
        .checked     (checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver side: random stall per cycle in the stalling phases
    always @(posedge clk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // watchdog: any accepted beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one access beat; random sender gaps ahead of it, returns once accepted
    task automatic send_beat(cmd_t cmd, logic [23:0] addr, logic [7:0] val,
                             logic [3:0] pin_port);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, pin_port, val, addr};
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // hold the sender until the checker has every result, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
    endtask

    // one full register setting, only written with the block idle
    task automatic write_setting(logic variant, logic [2:0] mode, logic p2_addr_bus,
                                 logic [23:0] base, logic [23:0] p9);
        write_reg(CFG_CHIP_VARIANT, {23'd0, variant});
        write_reg(CFG_OPERATING_MODE, {21'd0, mode});
        write_reg(CFG_P2_ADDR_BUS, {23'd0, p2_addr_bus});
        write_reg(CFG_BLOCK_BASE, base);
        write_reg(CFG_PORT9_ADDR, p9);
        cfg_wr_en <= 1'b0;
        cur_base = base;
        cur_p9   = p9;
    endtask

    // settings cover both variants, bus modes, window and port 9 at the extremes
    task automatic apply_setting(int ph);
        case (ph)
            0: write_setting(1'b0, MODE_SINGLE_CHIP, 1'b0, 24'h000100, 24'h000200);
            // window at the top, port 9 on the last byte: its data byte is gone
            1: write_setting(1'b1, MODE_SINGLE_CHIP, 1'b0, 24'hFFFFF0, 24'hFFFFFF);
            2: write_setting(1'b0, MODE_BUS16_A, 1'b1, 24'h001000, 24'h001010);
            // port 9 pair inside the window takes priority
            3: write_setting(1'b1, 3'd0, 1'b0, 24'h000000, 24'h000008);
            // window runs off the top of the address space
            4: write_setting(1'b0, MODE_BUS16_B, 1'b0, 24'hFFFFF8, 24'h000001);
            5: write_setting(1'b1, 3'd3, 1'b1, 24'h7FFFF0, 24'h000000);
            6: write_setting(1'($urandom_range(1)), 3'($urandom_range(7)),
                             1'($urandom_range(1)), 24'($urandom),
                             ($urandom_range(3) == 0) ? 24'h0 : 24'($urandom));
            default: write_setting(1'b0, MODE_SINGLE_CHIP, 1'b1, 24'h000000, 24'hFFFFFE);
        endcase
    endtask

    task automatic set_idling(int kind);
        case (kind)
            0: begin gap_pct = 0;             stall_pct = 0;             end
            1: begin gap_pct = IDLE_PCT;      stall_pct = 0;             end
            2: begin gap_pct = 0;             stall_pct = IDLE_PCT;      end
            default: begin gap_pct = BOTH_IDLE_PCT; stall_pct = BOTH_IDLE_PCT; end
        endcase
    endtask

    // directed beats, run with window at 0x100 and port 9 at 0x200 on variant 0
    task automatic directed_beats();
        send_beat(CMD_WRITE, cur_base + 24'd0,  8'hF0, PORT_1);   // port 1 direction
        send_beat(CMD_WRITE, cur_base + 24'd2,  8'hFF, PORT_1);   // port 1 latch
        send_beat(CMD_PIN,   24'h000000,        8'h00, PORT_1);
        send_beat(CMD_READ,  cur_base + 24'd2,  8'h00, PORT_1);   // latch and pins mixed
        send_beat(CMD_READ,  cur_base + 24'd0,  8'h00, PORT_1);   // direction reads ones
        send_beat(CMD_WRITE, cur_base + 24'd14, 8'h12, PORT_1);   // input-only port, dropped
        send_beat(CMD_PIN,   24'hFFFFFF,        8'hFF, PORT_INPUT_ONLY_A);
        send_beat(CMD_READ,  cur_base + 24'd14, 8'h00, PORT_1);   // low nibble of pins
        send_beat(CMD_READ,  cur_base + 24'd12, 8'h00, PORT_1);   // unused byte
        send_beat(CMD_WRITE, cur_base + 24'd12, 8'hFF, PORT_1);   // unused byte, ignored
        send_beat(CMD_WRITE, cur_p9,            8'h3C, PORT_1);
        send_beat(CMD_WRITE, cur_p9 + 24'd1,    8'hC3, PORT_1);
        send_beat(CMD_PIN,   24'h000000,        8'hFF, PORT_9);
        send_beat(CMD_READ,  cur_p9 + 24'd1,    8'h00, PORT_1);
        send_beat(CMD_READ,  cur_p9,            8'h00, PORT_1);
        send_beat(CMD_READ,  cur_base - 24'd1,  8'h00, PORT_1);   // just below the window
        send_beat(CMD_READ,  cur_base + 24'd16, 8'h00, PORT_1);   // just above it
        send_beat(CMD_PIN,   24'h000000,        8'hFF, 4'd0);      // pin port out of range
        send_beat(CMD_PIN,   24'h000000,        8'hAA, 4'd15);
        send_beat(CMD_NOP,   24'hFFFFFF,        8'hFF, 4'd15);
        send_beat(CMD_WRITE, 24'hFFFFFF,        8'hFF, PORT_1);   // unmapped write
        send_beat(CMD_READ,  24'h000000,        8'h00, PORT_1);
        send_beat(CMD_WRITE, cur_base + 24'd13, 8'h81, PORT_1);   // port 8 direction
        send_beat(CMD_READ,  cur_base + 24'd15, 8'h00, PORT_1);
    endtask

    // mostly window and port 9 addresses, some around the window edges, some anywhere
    task automatic send_random_beat();
        int          sel;
        int          kind;
        logic [23:0] addr;
        logic [3:0]  pin_port;
        cmd_t        cmd;
        sel = $urandom_range(99);
        if (sel < 62)
            addr = cur_base + 24'($urandom_range(15));
        else if (sel < 78 && cur_p9 != 24'h0)
            addr = cur_p9 + 24'($urandom_range(1));
        else if (sel < 88)
            addr = cur_base + 24'($urandom_range(31)) - 24'd8;
        else
            addr = 24'($urandom);
        kind = $urandom_range(99);
        if (kind < 36)
            cmd = CMD_READ;
        else if (kind < 72)
            cmd = CMD_WRITE;
        else if (kind < 92)
            cmd = CMD_PIN;
        else
            cmd = CMD_NOP;
        pin_port = ($urandom_range(99) < 85) ? 4'($urandom_range(9, 1))
                                             : 4'($urandom_range(15));
        send_beat(cmd, addr, 8'($urandom), pin_port);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_setting(ph);
            set_idling(ph % 4);
            if (ph == 0)
                directed_beats();
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // sender holds off mid-phase until every result is back
                if (n == BEATS_PER_PHASE / 2)
                    wait_drained();
                send_random_beat();
            end
            wait_drained();
        end
        $display("%0d access beats over %0d register settings and four idling patterns",
                 beats_sent, PHASES);
        $display("%0d result beats compared, %0d mismatches", checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/iop_pkg.sv
rtl/iop_decode.sv
rtl/io_port_register_block.sv
rtl/iop_checker.sv
verif/io_port_register_block_checker.sv
verif/tb_io_port_register_block.sv
